>>> src/rc4_pkg.sv
package rc4_pkg;

    localparam int PermDepth = 256;
    localparam int ByteW     = 8;
    localparam int KeyLenW   = 9;
    localparam logic [KeyLenW-1:0] KeyLenReset = 9'd16;

    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_STREAM = 2'd1,
        OP_XOR    = 2'd2,
        OP_SKIP   = 2'd3
    } t_op;

    // one write and one read port of the permutation memory
    typedef struct packed {
        logic             we;
        logic [ByteW-1:0] waddr;
        logic [ByteW-1:0] wdata;
        logic             re;
        logic [ByteW-1:0] raddr;
    } t_perm_req;

endpackage

>>> src/rc4_ram.sv
module rc4_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [rc4_pkg::ByteW-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [rc4_pkg::ByteW-1:0] o_rdata
);

    logic [rc4_pkg::ByteW-1:0] r_mem [DEPTH];
    logic [rc4_pkg::ByteW-1:0] r_rdata;

    // read returns the old contents on a same-cycle write; data holds while idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/rc4_ctrl.sv
module rc4_ctrl #(
    parameter int MAX_KEY_BYTES = 256,
    parameter int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
    parameter int CW = $clog2(MAX_KEY_BYTES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [rc4_pkg::ByteW-1:0]   i_data_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rc4_pkg::ByteW-1:0]   o_result_byte,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rc4_pkg::KeyLenW-1:0] i_cfg_key_length,
    output rc4_pkg::t_perm_req          o_perm_req,
    input  logic [rc4_pkg::ByteW-1:0]   i_perm_rdata,
    output logic                        o_key_we,
    output logic [KW-1:0]               o_key_waddr,
    output logic [rc4_pkg::ByteW-1:0]   o_key_wdata,
    output logic                        o_key_re,
    output logic [KW-1:0]               o_key_raddr,
    input  logic [rc4_pkg::ByteW-1:0]   i_key_rdata
);

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_GEN_B,
        S_GEN_C,
        S_GEN_D,
        S_KSA_RD,
        S_KSA_B,
        S_KSA_C,
        S_KSA_D
    } t_state;

    localparam logic [rc4_pkg::KeyLenW-1:0] MaxLen = rc4_pkg::KeyLenW'(MAX_KEY_BYTES);
    localparam logic [rc4_pkg::ByteW-1:0]   LastAddr = rc4_pkg::ByteW'(rc4_pkg::PermDepth - 1);
    localparam logic [rc4_pkg::ByteW-1:0]   ByteOne  = rc4_pkg::ByteW'(1);

    t_state                        r_state, n_state;
    rc4_pkg::t_op                  r_op, n_op;
    logic [rc4_pkg::ByteW-1:0]     r_data, n_data;
    logic [rc4_pkg::ByteW-1:0]     r_i, n_i;
    logic [rc4_pkg::ByteW-1:0]     r_j, n_j;
    logic [rc4_pkg::ByteW-1:0]     r_a, n_a;
    logic [rc4_pkg::ByteW-1:0]     r_b, n_b;
    logic [rc4_pkg::ByteW-1:0]     r_t, n_t;
    logic [rc4_pkg::ByteW-1:0]     r_addr, n_addr;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_kidx, n_kidx;
    logic                          r_fill_ksa, n_fill_ksa;
    logic [rc4_pkg::KeyLenW-1:0]   r_key_length, n_key_length;
    logic                          r_out_valid, n_out_valid;
    logic [rc4_pkg::ByteW-1:0]     r_out_data, n_out_data;

    logic [rc4_pkg::KeyLenW-1:0]   len_full;
    logic [CW-1:0]                 len;
    logic [CW-1:0]                 cnt_eff;
    logic [CW-1:0]                 cnt_inc;
    logic [CW-1:0]                 kidx_inc;
    logic [rc4_pkg::ByteW-1:0]     sum;
    logic [rc4_pkg::ByteW-1:0]     ks;
    logic                          need_out;
    logic                          d_go;
    logic                          in_acc;
    logic                          cfg_acc;
    rc4_pkg::t_op                  in_op;
    rc4_pkg::t_perm_req            preq;

    always_comb begin
        if (r_key_length == '0) begin
            len_full = rc4_pkg::KeyLenW'(1);
        end else if (r_key_length > MaxLen) begin
            len_full = MaxLen;
        end else begin
            len_full = r_key_length;
        end
    end

    assign len      = len_full[CW-1:0];
    assign cnt_eff  = (r_cnt >= len) ? '0 : r_cnt;
    assign cnt_inc  = cnt_eff + CW'(1);
    assign kidx_inc = (r_kidx + CW'(1) == len) ? '0 : r_kidx + CW'(1);
    assign in_op    = rc4_pkg::t_op'(i_operation);

    // output entry was read while S[j] was being written; S[i] is written after
    assign ks = (r_t == r_j) ? r_a : ((r_t == r_i) ? r_b : i_perm_rdata);

    assign need_out = (r_op == rc4_pkg::OP_STREAM) || (r_op == rc4_pkg::OP_XOR);
    assign d_go     = !need_out || !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) || ((r_state == S_GEN_D) && d_go);
    assign in_acc   = i_valid && o_ready;

    // key length is held while a key schedule (and its fill) runs
    assign o_cfg_ready = !r_fill_ksa &&
                         !(r_state inside {S_KSA_RD, S_KSA_B, S_KSA_C, S_KSA_D});
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_data       = r_data;
        n_i          = r_i;
        n_j          = r_j;
        n_a          = r_a;
        n_b          = r_b;
        n_t          = r_t;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_kidx       = r_kidx;
        n_fill_ksa   = r_fill_ksa;
        n_key_length = r_key_length;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        preq         = '0;
        o_key_we     = 1'b0;
        o_key_waddr  = cnt_eff[KW-1:0];
        o_key_wdata  = i_data_byte;
        o_key_re     = 1'b0;
        o_key_raddr  = r_kidx[KW-1:0];
        sum          = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_FILL: begin
                preq.we    = 1'b1;
                preq.waddr = r_addr;
                preq.wdata = r_addr;
                n_addr     = r_addr + ByteOne;
                if (r_addr == LastAddr) begin
                    n_state    = r_fill_ksa ? S_KSA_RD : S_IDLE;
                    n_fill_ksa = 1'b0;
                end
            end
            S_IDLE: begin
            end
            S_GEN_B: begin
                sum        = r_j + i_perm_rdata;
                n_a        = i_perm_rdata;
                n_j        = sum;
                preq.re    = 1'b1;
                preq.raddr = sum;
                n_state    = S_GEN_C;
            end
            S_GEN_C: begin
                sum        = r_a + i_perm_rdata;
                n_b        = i_perm_rdata;
                n_t        = sum;
                preq.we    = 1'b1;
                preq.waddr = r_j;
                preq.wdata = r_a;
                preq.re    = 1'b1;
                preq.raddr = sum;
                n_state    = S_GEN_D;
            end
            S_GEN_D: begin
                preq.we    = 1'b1;
                preq.waddr = r_i;
                preq.wdata = r_b;
                if (d_go) begin
                    n_state = S_IDLE;
                    if (need_out) begin
                        n_out_valid = 1'b1;
                        n_out_data  = (r_op == rc4_pkg::OP_XOR) ? (r_data ^ ks) : ks;
                    end
                end
            end
            S_KSA_RD: begin
                preq.re    = 1'b1;
                preq.raddr = r_addr;
                o_key_re   = 1'b1;
                n_state    = S_KSA_B;
            end
            S_KSA_B: begin
                sum        = r_j + i_perm_rdata + i_key_rdata;
                n_t        = i_perm_rdata;
                n_j        = sum;
                preq.re    = 1'b1;
                preq.raddr = sum;
                n_state    = S_KSA_C;
            end
            S_KSA_C: begin
                n_b        = i_perm_rdata;
                preq.we    = 1'b1;
                preq.waddr = r_j;
                preq.wdata = r_t;
                n_state    = S_KSA_D;
            end
            S_KSA_D: begin
                preq.we    = 1'b1;
                preq.waddr = r_addr;
                preq.wdata = r_b;
                n_addr     = r_addr + ByteOne;
                n_kidx     = kidx_inc;
                if (r_addr == LastAddr) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = S_IDLE;
                end else begin
                    preq.re     = 1'b1;
                    preq.raddr  = r_addr + ByteOne;
                    o_key_re    = 1'b1;
                    o_key_raddr = kidx_inc[KW-1:0];
                    n_state     = S_KSA_B;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (in_acc) begin
            n_op   = in_op;
            n_data = i_data_byte;
            if (in_op == rc4_pkg::OP_KEY) begin
                o_key_we = 1'b1;
                if (cnt_inc >= len) begin
                    n_cnt      = '0;
                    n_fill_ksa = 1'b1;
                    n_addr     = '0;
                    n_j        = '0;
                    n_kidx     = '0;
                    n_state    = S_FILL;
                end else begin
                    n_cnt   = cnt_inc;
                    n_state = S_IDLE;
                end
            end else begin
                n_i        = r_i + ByteOne;
                preq.re    = 1'b1;
                preq.raddr = r_i + ByteOne;
                n_state    = S_GEN_B;
            end
        end

        if (cfg_acc) begin
            n_key_length = i_cfg_key_length;
            n_cnt        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_i          <= '0;
            r_j          <= '0;
            r_addr       <= '0;
            r_cnt        <= '0;
            r_kidx       <= '0;
            r_fill_ksa   <= 1'b0;
            r_key_length <= rc4_pkg::KeyLenReset;
            r_out_valid  <= 1'b0;
            r_op         <= rc4_pkg::OP_KEY;
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_j          <= n_j;
            r_addr       <= n_addr;
            r_cnt        <= n_cnt;
            r_kidx       <= n_kidx;
            r_fill_ksa   <= n_fill_ksa;
            r_key_length <= n_key_length;
            r_out_valid  <= n_out_valid;
            r_op         <= n_op;
        end
        r_data     <= n_data;
        r_a        <= n_a;
        r_b        <= n_b;
        r_t        <= n_t;
        r_out_data <= n_out_data;
    end

    assign o_perm_req    = preq;
    assign o_valid       = r_out_valid;
    assign o_result_byte = r_out_data;

endmodule

>>> src/rc4_stream_cipher_unit.sv
// RC4 byte engine built around one 256x8 permutation memory (one write and one
// registered read port) and a key store of MAX_KEY_BYTES bytes. After reset the
// permutation memory is filled with the identity, one entry a cycle, while the
// input is not ready; configuration writes are taken at any time except while
// a key schedule, its identity fill included, is running. A key byte is written
// to the key store as it is taken; the byte that completes the key length
// triggers an identity fill and then the key schedule, which steps each entry
// through S_KSA_B, S_KSA_C and S_KSA_D (input not ready). Keystream, xor and skip
// transactions pass through S_GEN_B, S_GEN_C and S_GEN_D for the dependent reads
// of S[i], S[j] and S[S[i]+S[j]] on the single read port, and the next is taken
// in S_GEN_D; a waiting result holds the block only when the next result is due.
module rc4_stream_cipher_unit #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_result_byte,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [8:0]                  i_cfg_key_length
);

    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CW = $clog2(MAX_KEY_BYTES + 1);

    rc4_pkg::t_perm_req        perm_req;
    logic [rc4_pkg::ByteW-1:0] perm_rdata;
    logic                      key_we;
    logic [KW-1:0]             key_waddr;
    logic [rc4_pkg::ByteW-1:0] key_wdata;
    logic                      key_re;
    logic [KW-1:0]             key_raddr;
    logic [rc4_pkg::ByteW-1:0] key_rdata;

    rc4_ctrl #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .KW            (KW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_byte    (o_result_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_key_length (i_cfg_key_length),
        .o_perm_req       (perm_req),
        .i_perm_rdata     (perm_rdata),
        .o_key_we         (key_we),
        .o_key_waddr      (key_waddr),
        .o_key_wdata      (key_wdata),
        .o_key_re         (key_re),
        .o_key_raddr      (key_raddr),
        .i_key_rdata      (key_rdata)
    );

    rc4_ram #(
        .DEPTH (rc4_pkg::PermDepth),
        .AW    (rc4_pkg::ByteW)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_req.we),
        .i_waddr (perm_req.waddr),
        .i_wdata (perm_req.wdata),
        .i_re    (perm_req.re),
        .i_raddr (perm_req.raddr),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(
        .DEPTH (MAX_KEY_BYTES),
        .AW    (KW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MaxKeyBytes   = 256;
    localparam int          ItemsTarget   = 1350;
    // a completed key triggers an identity fill plus key schedule
    localparam int          SettleCycles  = 1200;
    localparam int          DrainCycles   = 50;
    localparam int          WatchdogLimit = 20000;
    localparam int          LongHold      = 300;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_operation      = rc4_pkg::OP_STREAM;
    logic [7:0]             i_data_byte      = 8'h00;
    logic                   o_valid;
    logic                   i_ready          = 1'b0;
    logic [7:0]             o_result_byte;
    logic                   i_cfg_valid      = 1'b0;
    logic                   o_cfg_ready;
    logic [rc4_pkg::KeyLenW-1:0] i_cfg_key_length = rc4_pkg::KeyLenReset;

    // cipher state as predicted
    logic [rc4_pkg::ByteW-1:0]   perm_m [rc4_pkg::PermDepth];
    logic [rc4_pkg::ByteW-1:0]   key_m  [MaxKeyBytes];
    logic [rc4_pkg::ByteW-1:0]   idx_i;
    logic [rc4_pkg::ByteW-1:0]   idx_j;
    int unsigned                 key_cnt;
    logic [rc4_pkg::KeyLenW-1:0] key_len_m;

    logic [rc4_pkg::ByteW-1:0]   expected_bytes [$];
    logic [rc4_pkg::ByteW-1:0]   want_byte;
    int unsigned            err_count    = 0;
    int unsigned            items_sent   = 0;
    int unsigned            burst_left   = 0;
    int unsigned            stuck_cycles = 0;
    bit                     idle_on      = 1'b1;
    int unsigned            hold_request = 0;
    int unsigned            hold_left    = 0;
    int unsigned            rx_run       = 0;
    bit                     rx_stall     = 1'b0;

    rc4_stream_cipher_unit #(
        .MAX_KEY_BYTES (MaxKeyBytes)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_byte    (o_result_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_key_length (i_cfg_key_length)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- cipher prediction ----------------

    function automatic int unsigned key_len_in_use();
        if (key_len_m == 0) return 1;
        if (key_len_m > MaxKeyBytes) return MaxKeyBytes;
        return int'(key_len_m);
    endfunction

    function automatic void clear_cipher_state();
        for (int a = 0; a < rc4_pkg::PermDepth; a++) perm_m[a] = rc4_pkg::ByteW'(a);
        for (int a = 0; a < MaxKeyBytes; a++) key_m[a] = '0;
        idx_i     = '0;
        idx_j     = '0;
        key_cnt   = 0;
        key_len_m = rc4_pkg::KeyLenReset;
    endfunction

    function automatic void schedule_key(int unsigned len);
        logic [rc4_pkg::ByteW-1:0] b;
        logic [rc4_pkg::ByteW-1:0] t;
        b = '0;
        for (int a = 0; a < rc4_pkg::PermDepth; a++) perm_m[a] = rc4_pkg::ByteW'(a);
        for (int a = 0; a < rc4_pkg::PermDepth; a++) begin
            t         = perm_m[a];
            b         = b + t + key_m[a % len];
            perm_m[a] = perm_m[b];
            perm_m[b] = t;
        end
        idx_i = '0;
        idx_j = '0;
    endfunction

    function automatic logic [rc4_pkg::ByteW-1:0] keystream_step();
        logic [rc4_pkg::ByteW-1:0] t;
        logic [rc4_pkg::ByteW-1:0] k;
        idx_i         = idx_i + 8'd1;
        idx_j         = idx_j + perm_m[idx_i];
        t             = perm_m[idx_j];
        perm_m[idx_j] = perm_m[idx_i];
        perm_m[idx_i] = t;
        k             = perm_m[idx_i] + perm_m[idx_j];
        return perm_m[k];
    endfunction

    function automatic void apply_cipher_op(rc4_pkg::t_op op, logic [rc4_pkg::ByteW-1:0] data);
        int unsigned len;
        len = key_len_in_use();
        case (op)
            rc4_pkg::OP_KEY: begin
                if (key_cnt >= len) key_cnt = 0;
                key_m[key_cnt] = data;
                key_cnt++;
                if (key_cnt >= len) begin
                    schedule_key(len);
                    key_cnt = 0;
                end
            end
            rc4_pkg::OP_STREAM: expected_bytes.push_back(keystream_step());
            rc4_pkg::OP_XOR:    expected_bytes.push_back(data ^ keystream_step());
            default:            void'(keystream_step());
        endcase
    endfunction

    // ---------------- checking ----------------

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bytes.size() == 0) begin
                report_error($sformatf("result 0x%02h with nothing expected", o_result_byte));
            end else begin
                want_byte = expected_bytes.pop_front();
                if (o_result_byte !== want_byte)
                    report_error($sformatf("result_byte expected 0x%02h actual 0x%02h",
                                           want_byte, o_result_byte));
            end
        end
    end

    // receiver: random stall runs, always ready with idle_on off, or a long hold when a test asks for one
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!idle_on) begin
            i_ready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_run   = $urandom_range(1, 9);
                rx_stall = ($urandom_range(0, 9) < 3);
            end
            rx_run--;
            i_ready <= !rx_stall;
        end
    end

    initial begin : watchdog
        while (stuck_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // ---------------- stimulus helpers ----------------

    // called just after a rising edge; returns at the edge that takes the transaction
    task automatic send_item(input rc4_pkg::t_op op, input logic [rc4_pkg::ByteW-1:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = idle_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_cipher_op(op, data);
        items_sent++;
    endtask

    task automatic wait_results();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_key_length(input logic [rc4_pkg::KeyLenW-1:0] len);
        wait_results();
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_key_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        key_len_m = len;
        key_cnt   = 0;
    endtask

    task automatic load_key(input int unsigned n);
        repeat (n) send_item(rc4_pkg::OP_KEY, rc4_pkg::ByteW'($urandom_range(0, 255)));
    endtask

    task automatic send_generator_ops(input int unsigned n);
        repeat (n) send_item(rc4_pkg::t_op'($urandom_range(1, 3)),
                             rc4_pkg::ByteW'($urandom_range(0, 255)));
    endtask

    // ---------------- tests ----------------

    // identity permutation straight out of reset
    task automatic test_stream_before_key();
        send_item(rc4_pkg::OP_STREAM, 8'hFF);
        send_item(rc4_pkg::OP_XOR, 8'h00);
        send_item(rc4_pkg::OP_XOR, 8'hFF);
        send_item(rc4_pkg::OP_SKIP, 8'hA5);
        send_item(rc4_pkg::OP_STREAM, 8'h00);
    endtask

    // key length left at its reset value
    task automatic test_reset_key_length();
        send_item(rc4_pkg::OP_KEY, 8'h00);
        send_item(rc4_pkg::OP_KEY, 8'hFF);
        load_key(14);
        send_item(rc4_pkg::OP_STREAM, 8'h5A);
        send_item(rc4_pkg::OP_XOR, 8'hFF);
        send_item(rc4_pkg::OP_SKIP, 8'h00);
        send_item(rc4_pkg::OP_XOR, 8'h00);
    endtask

    // a length write mid-load drops the bytes collected so far
    task automatic test_partial_key_dropped();
        load_key(5);
        set_key_length(9'd3);
        load_key(3);
        send_generator_ops(4);
    endtask

    task automatic test_key_length_extremes();
        set_key_length(9'd0);
        send_item(rc4_pkg::OP_KEY, 8'hFF);
        send_generator_ops(3);
        set_key_length(9'd1);
        send_item(rc4_pkg::OP_KEY, 8'h00);
        send_generator_ops(3);
        set_key_length(9'd256);
        load_key(256);
        send_generator_ops(3);
        set_key_length(9'h1FF);
        load_key(256);
        send_generator_ops(3);
    endtask

    // output held off while the sender keeps going
    task automatic test_output_backpressure();
        idle_on      = 1'b0;
        hold_request = LongHold;
        repeat (40) send_item(rc4_pkg::OP_STREAM, 8'h00);
        wait_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [rc4_pkg::KeyLenW-1:0] len;
        int unsigned                 n_keys;
        int unsigned                 eff;
        while (items_sent < ItemsTarget) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                len = rc4_pkg::KeyLenW'($urandom_range(0, 511));
            else
                len = rc4_pkg::KeyLenW'($urandom_range(1, 8));
            set_key_length(len);
            eff    = key_len_in_use();
            n_keys = (eff > 16) ? 1 : $urandom_range(2, 4);
            repeat (n_keys) begin
                if ($urandom_range(0, 4) != 0)
                    load_key(eff);
                else
                    load_key($urandom_range(1, eff));
                send_generator_ops($urandom_range(5, 40));
                if ($urandom_range(0, 3) == 0)
                    send_item(rc4_pkg::t_op'($urandom_range(0, 3)),
                              rc4_pkg::ByteW'($urandom_range(0, 255)));
                if ($urandom_range(0, 5) == 0)
                    wait_results();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        clear_cipher_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stream_before_key();
        test_reset_key_length();
        test_partial_key_dropped();
        test_key_length_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_results();
        repeat (DrainCycles) @(posedge i_clk);
        if (err_count == 0 && expected_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
